@@ sv/psfd_pkg.sv @@
// ----------------------------------------------------------------------------
// psfd_pkg
// Shared types and constants of the position sensor frame decoder.
// ----------------------------------------------------------------------------
package psfd_pkg;

  localparam int FRAME_BYTES = 21;
  localparam int POS_W       = 5;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  localparam int X_W     = 24;
  localparam int Y_W     = 14;
  localparam int ANGLE_W = 14;
  localparam int HEAD_W  = 12;
  localparam int TAG_W   = 24;
  localparam int WRAP_W  = 16;

  localparam int DET_BIT = 6;

  localparam logic signed [WRAP_W-1:0] WRAP_LOW  = -16'sd1800;
  localparam logic signed [WRAP_W-1:0] WRAP_HIGH = 16'sd1799;
  localparam int WRAP_STEPS = 7;
  localparam int WRAP_MID   = 3;
  localparam int WRAP_TURN  = 3600;

  typedef struct packed {
    logic               ok;
    logic               det;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [ANGLE_W-1:0] angle;
    logic [TAG_W-1:0]   tag;
  } frame_t;

endpackage

@@ sv/psfd_front.sv @@
// ----------------------------------------------------------------------------
// psfd_front
// Byte intake: frame position, running xor and capture of the decoded fields.
// ----------------------------------------------------------------------------
module psfd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             frame_start,
  output logic             push,
  output psfd_pkg::frame_t push_data,
  input  logic             q_full
);
  import psfd_pkg::*;

  localparam logic [POS_W-1:0] POS_FLAGS = 5'd1;
  localparam logic [POS_W-1:0] POS_X0    = 5'd2;
  localparam logic [POS_W-1:0] POS_X1    = 5'd3;
  localparam logic [POS_W-1:0] POS_X2    = 5'd4;
  localparam logic [POS_W-1:0] POS_X3    = 5'd5;
  localparam logic [POS_W-1:0] POS_Y0    = 5'd6;
  localparam logic [POS_W-1:0] POS_Y1    = 5'd7;
  localparam logic [POS_W-1:0] POS_A0    = 5'd10;
  localparam logic [POS_W-1:0] POS_A1    = 5'd11;
  localparam logic [POS_W-1:0] POS_T0    = 5'd14;
  localparam logic [POS_W-1:0] POS_T1    = 5'd15;
  localparam logic [POS_W-1:0] POS_T2    = 5'd16;
  localparam logic [POS_W-1:0] POS_T3    = 5'd17;

  logic [POS_W-1:0]   pos;
  logic [7:0]         xor_acc;
  logic [POS_W-1:0]   pos_eff;
  logic [7:0]         xor_eff;
  logic               accept;
  logic               det;
  logic [X_W-1:0]     x_raw;
  logic [Y_W-1:0]     y_raw;
  logic [ANGLE_W-1:0] angle_raw;
  logic [TAG_W-1:0]   tag_raw;
  logic               ok;
  logic               keep;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pos_eff  = frame_start ? '0 : pos;
  assign xor_eff  = frame_start ? 8'h00 : xor_acc;
  assign ok       = (xor_eff == rx_byte);
  assign keep     = ok && det;

  assign push = accept && (pos_eff == LAST_POS);
  always_comb begin
    push_data       = '0;
    push_data.ok    = ok;
    push_data.det   = keep;
    if (keep) begin
      push_data.x     = x_raw;
      push_data.y     = y_raw;
      push_data.angle = angle_raw;
      push_data.tag   = tag_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      xor_acc <= 8'h00;
    end else if (accept) begin
      if (pos_eff == LAST_POS) begin
        pos     <= '0;
        xor_acc <= 8'h00;
      end else begin
        pos     <= pos_eff + POS_W'(1);
        xor_acc <= xor_eff ^ rx_byte;
      end
    end
  end

  // field capture at fixed byte positions
  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (pos_eff)
        POS_FLAGS: det               <= rx_byte[DET_BIT];
        POS_X0:    x_raw[23:21]      <= rx_byte[2:0];
        POS_X1:    x_raw[20:14]      <= rx_byte[6:0];
        POS_X2:    x_raw[13:7]       <= rx_byte[6:0];
        POS_X3:    x_raw[6:0]        <= rx_byte[6:0];
        POS_Y0:    y_raw[13:7]       <= rx_byte[6:0];
        POS_Y1:    y_raw[6:0]        <= rx_byte[6:0];
        POS_A0:    angle_raw[13:7]   <= rx_byte[6:0];
        POS_A1:    angle_raw[6:0]    <= rx_byte[6:0];
        POS_T0:    tag_raw[23:21]    <= rx_byte[2:0];
        POS_T1:    tag_raw[20:14]    <= rx_byte[6:0];
        POS_T2:    tag_raw[13:7]     <= rx_byte[6:0];
        POS_T3:    tag_raw[6:0]      <= rx_byte[6:0];
        default:   ;
      endcase
    end
  end

endmodule

@@ sv/psfd_queue.sv @@
// ----------------------------------------------------------------------------
// psfd_queue
// Two-entry queue of decoded frames between intake and output stage.
// ----------------------------------------------------------------------------
module psfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  psfd_pkg::frame_t push_data,
  output logic             full,
  output logic             q_valid,
  output psfd_pkg::frame_t q_data,
  input  logic             pop
);
  import psfd_pkg::*;

  frame_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ sv/psfd_back.sv @@
// ----------------------------------------------------------------------------
// psfd_back
// Output stage: heading wrap and negation, result register.
// ----------------------------------------------------------------------------
module psfd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [psfd_pkg::HEAD_W-1:0]    cfg_wdata,
  input  logic                           q_valid,
  input  psfd_pkg::frame_t               q_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           checksum_ok,
  output logic                           tag_detected,
  output logic signed [psfd_pkg::X_W-1:0]    x_offset,
  output logic signed [psfd_pkg::Y_W-1:0]    y_offset,
  output logic signed [psfd_pkg::HEAD_W-1:0] heading,
  output logic [psfd_pkg::TAG_W-1:0]     tag_code
);
  import psfd_pkg::*;

  logic [HEAD_W-1:0]        offset;
  logic signed [WRAP_W-1:0] diff;
  logic signed [WRAP_W-1:0] cand;
  logic signed [WRAP_W-1:0] wrapped;
  logic signed [WRAP_W-1:0] negated;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cfg_we) begin
      offset <= cfg_wdata;
    end
  end

  assign diff = $signed({{(WRAP_W-ANGLE_W){q_data.angle[ANGLE_W-1]}}, q_data.angle})
              - $signed({{(WRAP_W-HEAD_W){offset[HEAD_W-1]}}, offset});

  // fold into -1800..1799 by whole turns
  always_comb begin
    wrapped = diff;
    cand    = diff;
    for (int k = 0; k < WRAP_STEPS; k++) begin
      cand = diff + WRAP_W'((k - WRAP_MID) * WRAP_TURN);
      if (cand >= WRAP_LOW && cand <= WRAP_HIGH) begin
        wrapped = cand;
      end
    end
  end

  assign negated = -wrapped;
  assign pop     = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      checksum_ok  <= q_data.ok;
      tag_detected <= q_data.det;
      x_offset     <= q_data.x;
      y_offset     <= q_data.y;
      heading      <= q_data.det ? negated[HEAD_W-1:0] : '0;
      tag_code     <= q_data.tag;
    end
  end

endmodule

@@ sv/position_sensor_frame_decoder_top.sv @@
// ----------------------------------------------------------------------------
// position_sensor_frame_decoder_top
// Decodes 21-byte sensor response frames into checksum verdict and tag pose.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   rx_byte, frame_start
//   output    out_valid / out_ready checksum_ok, tag_detected, x_offset,
//                                   y_offset, heading, tag_code
//   config    cfg_we                cfg_wdata (heading offset)
//
// one byte transaction per cycle while in_ready; frames are queued, then registered
// rst is synchronous and clears the byte counter, xor, queue and offset
// the two-entry frame queue decouples intake from the result register;
// in_ready drops only while the queue is full
// ----------------------------------------------------------------------------
module position_sensor_frame_decoder_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         rx_byte,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               checksum_ok,
  output logic                               tag_detected,
  output logic signed [psfd_pkg::X_W-1:0]    x_offset,
  output logic signed [psfd_pkg::Y_W-1:0]    y_offset,
  output logic signed [psfd_pkg::HEAD_W-1:0] heading,
  output logic [psfd_pkg::TAG_W-1:0]         tag_code,
  input  logic                               cfg_we,
  input  logic [psfd_pkg::HEAD_W-1:0]        cfg_wdata
);
  import psfd_pkg::*;

  logic   push;
  frame_t push_data;
  logic   q_full;
  logic   q_valid;
  frame_t q_data;
  logic   pop;

  psfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  psfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop)
  );

  psfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .checksum_ok  (checksum_ok),
    .tag_detected (tag_detected),
    .x_offset     (x_offset),
    .y_offset     (y_offset),
    .heading      (heading),
    .tag_code     (tag_code)
  );

endmodule
